[rtl/core/ookenc_pkg.sv]
// Package for the OOK remote frame encoder: shared types, constants,
// the CRC-16 byte update, the symbol expansion and the preamble table.
// No dependencies.
package ookenc_pkg;

    localparam int FRAME_LEN    = 6;
    localparam int PREAMBLE_LEN = 6;
    localparam int PKT_BYTES    = 25;
    localparam int STREAM_W     = FRAME_LEN * 8 * 3;
    localparam int CRC_STAGES   = 4;
    localparam int FIFO_DEPTH   = 2;

    localparam logic [15:0] CRC_POLY        = 16'h8005;
    localparam logic [7:0]  DEV_ADDR_RESET  = 8'h00;
    localparam logic [7:0]  FIXED_A_RESET   = 8'h27;
    localparam logic [7:0]  FIXED_B_RESET   = 8'h48;
    localparam logic [7:0]  CLOSING_BYTE    = 8'h80;
    localparam logic [4:0]  LAST_IDX        = 5'(PKT_BYTES - 1);

    typedef enum logic [1:0] {
        CFG_DEVICE_ADDRESS,
        CFG_FIXED_BYTE_A,
        CFG_FIXED_BYTE_B
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] fixed_byte_a;
        logic [7:0] fixed_byte_b;
    } cfg_t;

    typedef struct packed {
        logic                          rep;
        logic [FRAME_LEN-1:0][7:0]     bytes;
    } frame_t;

    // CRC-16, MSB first, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Each frame bit, bytes in order and LSB first, becomes 1b0; first symbol on top
    function automatic logic [STREAM_W-1:0] expand_frame(
        input logic [FRAME_LEN-1:0][7:0] bytes);
        logic [STREAM_W-1:0] s;
        int j;
        s = '0;
        for (int i = 0; i < FRAME_LEN; i++) begin
            for (int b = 0; b < 8; b++) begin
                j = i * 8 + b;
                s[STREAM_W-1-3*j] = 1'b1;
                s[STREAM_W-2-3*j] = bytes[i][b];
                s[STREAM_W-3-3*j] = 1'b0;
            end
        end
        return s;
    endfunction

    function automatic logic [7:0] preamble_byte(input logic [2:0] idx,
                                                 input logic       rep);
        logic [7:0] v;
        case (idx)
            3'd0:    v = rep ? 8'h00 : 8'h07;
            3'd1:    v = rep ? 8'h02 : 8'hC2;
            3'd2:    v = 8'hAA;
            3'd3:    v = 8'hAA;
            3'd4:    v = 8'hA8;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/ookenc_front.sv]
// Front end: accepts command beats and runs a four-stage CRC pipeline,
// one frame byte per stage. Depends on ookenc_pkg.
module ookenc_front import ookenc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_command,
    input  logic       s_repeat_frame,
    output logic       push,
    output frame_t     push_data,
    input  logic       push_ready
);

    logic [CRC_STAGES-1:0]                 stg_valid_reg;
    logic [CRC_STAGES-1:0][15:0]           stg_crc_reg;
    logic [CRC_STAGES-1:0][3:0][7:0]       stg_bytes_reg;
    logic [CRC_STAGES-1:0]                 stg_rep_reg;
    logic [CRC_STAGES-1:0]                 stg_ready;
    logic [3:0][7:0]                       in_bytes;

    assign in_bytes = {cfg.fixed_byte_b, cfg.fixed_byte_a, s_command, cfg.device_address};

    always_comb begin
        stg_ready[CRC_STAGES-1] = !stg_valid_reg[CRC_STAGES-1] || push_ready;
        for (int k = CRC_STAGES - 2; k >= 0; k--) begin
            stg_ready[k] = !stg_valid_reg[k] || stg_ready[k+1];
        end
    end

    assign s_ready = stg_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= '0;
        end else begin
            if (stg_ready[0]) begin
                stg_valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < CRC_STAGES; k++) begin
                if (stg_ready[k]) begin
                    stg_valid_reg[k] <= stg_valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && stg_ready[0]) begin
            stg_crc_reg[0]   <= crc16_byte(16'h0000, in_bytes[0]);
            stg_bytes_reg[0] <= in_bytes;
            stg_rep_reg[0]   <= s_repeat_frame;
        end
        for (int k = 1; k < CRC_STAGES; k++) begin
            if (stg_valid_reg[k-1] && stg_ready[k]) begin
                stg_crc_reg[k]   <= crc16_byte(stg_crc_reg[k-1], stg_bytes_reg[k-1][k]);
                stg_bytes_reg[k] <= stg_bytes_reg[k-1];
                stg_rep_reg[k]   <= stg_rep_reg[k-1];
            end
        end
    end

    assign push = stg_valid_reg[CRC_STAGES-1] && push_ready;

    always_comb begin
        push_data.rep         = stg_rep_reg[CRC_STAGES-1];
        push_data.bytes[3:0]  = stg_bytes_reg[CRC_STAGES-1];
        push_data.bytes[4]    = stg_crc_reg[CRC_STAGES-1][15:8];
        push_data.bytes[5]    = stg_crc_reg[CRC_STAGES-1][7:0];
    end

endmodule

[rtl/core/ookenc_fifo.sv]
// Small register queue between the front end and the byte emitter.
// No package dependency.
module ookenc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             pop_valid
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign push_ready = count_reg != (AW+1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/ookenc_back.sv]
// Back end: emits the 25 packet bytes of one frame, one beat per cycle while
// the receiver is ready, through an output register. Depends on ookenc_pkg.
module ookenc_back import ookenc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  frame_t     q_data,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_packet_byte,
    output logic [4:0] m_byte_index,
    output logic       m_last_byte
);

    logic                busy_reg;
    logic [4:0]          idx_reg;
    logic                rep_reg;
    logic [STREAM_W-1:0] stream_reg;
    logic                m_valid_reg;
    logic [7:0]          byte_reg;
    logic [4:0]          index_reg;
    logic                last_reg;
    logic                adv;
    logic [7:0]          byte_next;

    assign adv   = busy_reg && (!m_valid_reg || m_ready);
    assign q_pop = q_valid && (!busy_reg || (adv && idx_reg == LAST_IDX));

    always_comb begin
        if (idx_reg < 5'(PREAMBLE_LEN)) begin
            byte_next = preamble_byte(idx_reg[2:0], rep_reg);
        end else if (idx_reg == LAST_IDX) begin
            byte_next = CLOSING_BYTE;
        end else begin
            byte_next = stream_reg[STREAM_W-1 -: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // a new frame takes over in the cycle the old one ends
            if (q_pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (adv) begin
                if (idx_reg == LAST_IDX) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            byte_reg  <= byte_next;
            index_reg <= idx_reg;
            last_reg  <= idx_reg == LAST_IDX;
        end
        if (q_pop) begin
            stream_reg <= expand_frame(q_data.bytes);
            rep_reg    <= q_data.rep;
        end else if (adv && idx_reg >= 5'(PREAMBLE_LEN)) begin
            stream_reg <= {stream_reg[STREAM_W-9:0], 8'h00};
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_packet_byte = byte_reg;
    assign m_byte_index  = index_reg;
    assign m_last_byte   = last_reg;

endmodule

[rtl/core/ook_remote_frame_encoder.sv]
// OOK remote frame encoder, top level.
// Input channel (s_*): one beat carries a command byte and a repeat flag.
// Output channel (m_*): 25 beats per command, each one raw OOK packet byte
// (sent MSB first on air), its position 0..24 and a last-byte marker.
// Configuration: cfg_wr_en/cfg_index/cfg_data write device address and the
// two fixed frame bytes; write only while the block is idle.
// A command passes the four CRC stages, the queue, the emitter load and the
// output register before the first byte of its packet appears.
// The byte-wide output channel limits throughput to 25 beats per command; a
// queued command is loaded as the previous last byte is registered, so
// packets follow without a gap, and commands keep being taken into the CRC
// pipeline and queue meanwhile.
// Reset (aresetn low, synchronous) empties the pipeline, queue and output
// register and restores the registers to 0x00, 0x27, 0x48.
// A stalled receiver holds the current beat; the emitter, then the queue and
// finally the input channel back up behind it without loss.
// Depends on ookenc_pkg, ookenc_front, ookenc_fifo and ookenc_back.
module ook_remote_frame_encoder import ookenc_pkg::*; #(
    parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_command,
    input  logic       s_repeat_frame,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_packet_byte,
    output logic [4:0] m_byte_index,
    output logic       m_last_byte
);

    cfg_t   cfg_reg;
    logic   q_push;
    logic   q_push_ready;
    frame_t q_push_data;
    logic   q_pop;
    logic   q_valid;
    frame_t q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= DEV_ADDR_RESET;
            cfg_reg.fixed_byte_a   <= FIXED_A_RESET;
            cfg_reg.fixed_byte_b   <= FIXED_B_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data;
                CFG_FIXED_BYTE_A:   cfg_reg.fixed_byte_a   <= cfg_data;
                CFG_FIXED_BYTE_B:   cfg_reg.fixed_byte_b   <= cfg_data;
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    ookenc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_repeat_frame (s_repeat_frame),
        .push           (q_push),
        .push_data      (q_push_data),
        .push_ready     (q_push_ready)
    );

    ookenc_fifo #(
        .WIDTH ($bits(frame_t)),
        .DEPTH (FIFO_DEPTH_P)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_data   (q_data),
        .pop_valid  (q_valid)
    );

    ookenc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packet_byte (m_packet_byte),
        .m_byte_index  (m_byte_index),
        .m_last_byte   (m_last_byte)
    );

`ifndef SYNTH
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_push_ready)
        else $error("queue pushed while full");

    a_packet_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_byte) |=>
            (m_valid && m_byte_index == $past(m_byte_index) + 5'd1))
        else $error("packet byte sequence broken");

    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_byte == (m_byte_index == LAST_IDX)))
        else $error("last byte marker misplaced");
`endif

endmodule

[dv/ook_remote_frame_encoder_test.sv]
// Self-checking testbench for ook_remote_frame_encoder: directed table, then random commands
// under bursty input and a stalling receiver, checked byte by byte against an in-bench encoder.
// Depends on ookenc_pkg and the encoder RTL only.
module ook_remote_frame_encoder_test;
    import ookenc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam logic [7:0] WAKELESS_B0  = 8'h00;
    localparam logic [7:0] WAKELESS_B1  = 8'h02;
    localparam int         RANDOM_ITEMS = 234;
    localparam int         REG_PERIOD   = 40;
    localparam logic [7:0] PREAMBLE [PREAMBLE_LEN] = '{8'h07, 8'hC2, 8'hAA, 8'hAA, 8'hA8, 8'h00};

    typedef logic [PKT_BYTES-1:0][7:0] packet_t;

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] index;
        logic       last;
    } ook_beat_t;

    typedef struct packed {
        logic       set_regs;
        logic [7:0] addr;
        logic [7:0] fa;
        logic [7:0] fb;
        logic [7:0] cmd;
        logic       rep;
        logic       typed;
        logic [7:0] head0;
        logic [7:0] head1;
    } row_t;

    // set_regs, addr, fixed a, fixed b, command, repeat, typed, byte 0, byte 1
    localparam row_t PLAN [16] = '{
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h07, 8'hC2},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 8'h07, 8'hC2},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 8'h02},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 8'h00, 8'h02},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'hAA, 1'b1, 1'b0, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1, 8'h07, 8'hC2},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 8'h00, 8'h02},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'h5A, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h07, 8'hC2},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00},
        '{1'b1, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b0, 1'b0, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'h00, 8'h00, 8'hC3, 1'b1, 1'b0, 8'h00, 8'h00},
        '{1'b1, 8'h00, 8'h27, 8'h48, 8'h12, 1'b0, 1'b0, 8'h00, 8'h00}
    };

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       cfg_wr_en      = 1'b0;
    logic [1:0] cfg_index      = 2'd0;
    logic [7:0] cfg_data       = 8'h00;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_command      = 8'h00;
    logic       s_repeat_frame = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_packet_byte;
    logic [4:0] m_byte_index;
    logic       m_last_byte;

    logic [7:0] dev_addr_q = DEV_ADDR_RESET;
    logic [7:0] byte_a_q   = FIXED_A_RESET;
    logic [7:0] byte_b_q   = FIXED_B_RESET;

    ook_beat_t  due_bytes [$];
    ook_beat_t  head_beat;
    int         mismatches = 0;
    logic [9:0] stall_phase = '0;

    ook_remote_frame_encoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_repeat_frame (s_repeat_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packet_byte  (m_packet_byte),
        .m_byte_index   (m_byte_index),
        .m_last_byte    (m_last_byte)
    );

    always #10 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("ook_remote_frame_encoder verification failed");
        $finish;
    end

    // Frame, CRC (bit serial) and symbol stream from the bench's register copies
    function automatic packet_t encode_packet(input logic [7:0] cmd, input logic rep);
        logic [7:0]          frame [FRAME_LEN];
        logic [15:0]         crc;
        logic                fb;
        logic [STREAM_W-1:0] stream;
        packet_t             pkt;
        frame[0] = dev_addr_q;
        frame[1] = cmd;
        frame[2] = byte_a_q;
        frame[3] = byte_b_q;
        crc = '0;
        for (int i = 0; i < 4; i++) begin
            for (int k = 7; k >= 0; k--) begin
                fb  = crc[15] ^ frame[i][k];
                crc = {crc[14:0], 1'b0};
                if (fb) begin
                    crc = crc ^ CRC_POLY;
                end
            end
        end
        frame[4] = crc[15:8];
        frame[5] = crc[7:0];
        stream = '0;
        for (int i = 0; i < FRAME_LEN; i++) begin
            for (int k = 0; k < 8; k++) begin
                stream = {stream[STREAM_W-4:0], 1'b1, frame[i][k], 1'b0};
            end
        end
        for (int i = 0; i < PREAMBLE_LEN; i++) begin
            pkt[i] = PREAMBLE[i];
        end
        if (rep) begin
            pkt[0] = WAKELESS_B0;
            pkt[1] = WAKELESS_B1;
        end
        for (int k = 0; k < PKT_BYTES - PREAMBLE_LEN - 1; k++) begin
            pkt[PREAMBLE_LEN + k] = stream[STREAM_W - 1 - 8 * k -: 8];
        end
        pkt[PKT_BYTES-1] = CLOSING_BYTE;
        return pkt;
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = 8'h01 << $urandom_range(0, 7);
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    // Hold valid and payload until the beat is taken, then queue its 25 bytes
    task automatic send_item(input logic [7:0] cmd, input logic rep, input packet_t pkt);
        ook_beat_t b;
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_repeat_frame <= rep;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        for (int i = 0; i < PKT_BYTES; i++) begin
            b.data  = pkt[i];
            b.index = 5'(i);
            b.last  = (5'(i) == LAST_IDX);
            due_bytes.push_back(b);
        end
    endtask

    task automatic rest(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            CFG_DEVICE_ADDRESS: dev_addr_q = val;
            CFG_FIXED_BYTE_A:   byte_a_q   = val;
            CFG_FIXED_BYTE_B:   byte_b_q   = val;
            default: ;
        endcase
    endtask

    // Drain first: registers change only with nothing in flight
    task automatic program_regs(input logic [7:0] addr, input logic [7:0] fa,
                                input logic [7:0] fb);
        while (due_bytes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        put_reg(CFG_DEVICE_ADDRESS, addr);
        put_reg(CFG_FIXED_BYTE_A, fa);
        put_reg(CFG_FIXED_BYTE_B, fb);
        put_reg(CFG_UNUSED, pick_byte());
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: always ready, light random stalls, one beat in eight, long stalls
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 10'd1;
        case (stall_phase[9:8])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_ready <= (stall_phase[2:0] == 3'd0);
            default: m_ready <= (stall_phase[4:0] < 5'd20);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, got byte %02h index %0d",
                         $time, m_packet_byte, m_byte_index);
            end else begin
                head_beat = due_bytes.pop_front();
                if (m_packet_byte !== head_beat.data) begin
                    mismatches++;
                    $display("%0t: packet_byte at index %0d: expected %02h, got %02h",
                             $time, head_beat.index, head_beat.data, m_packet_byte);
                end
                if (m_byte_index !== head_beat.index) begin
                    mismatches++;
                    $display("%0t: byte_index: expected %0d, got %0d",
                             $time, head_beat.index, m_byte_index);
                end
                if (m_last_byte !== head_beat.last) begin
                    mismatches++;
                    $display("%0t: last_byte at index %0d: expected %0b, got %0b",
                             $time, head_beat.index, head_beat.last, m_last_byte);
                end
            end
        end
    end

    initial begin
        packet_t    pkt;
        int         burst_left;
        logic [7:0] cmd;
        logic       rep;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (PLAN[r]) begin
            if (PLAN[r].set_regs) begin
                rest(1);
                program_regs(PLAN[r].addr, PLAN[r].fa, PLAN[r].fb);
            end
            pkt = encode_packet(PLAN[r].cmd, PLAN[r].rep);
            if (PLAN[r].typed) begin
                pkt[0] = PLAN[r].head0;
                pkt[1] = PLAN[r].head1;
            end
            send_item(PLAN[r].cmd, PLAN[r].rep, pkt);
            rest($urandom_range(0, 2));
        end

        burst_left = $urandom_range(1, 10);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % REG_PERIOD == REG_PERIOD - 1) begin
                rest(1);
                program_regs(pick_byte(), pick_byte(), pick_byte());
            end
            cmd = pick_byte();
            rep = 1'($urandom_range(0, 1));
            send_item(cmd, rep, encode_packet(cmd, rep));
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                rest(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            end else begin
                burst_left--;
            end
        end

        rest(1);
        while (due_bytes.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ook_remote_frame_encoder verification clean");
        end else begin
            $display("ook_remote_frame_encoder verification failed");
        end
        $finish;
    end

endmodule
